// ----- hdl/gps_pkg.sv -----
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types and constants of the gait phase scheduler: configuration
// record, controller/datapath command and status, state and code enums.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int unsigned MAX_LEGS   = 4;
  localparam int unsigned LEG_IDX_W  = 2;
  localparam int unsigned ROW_CAP    = 16;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned ROWS_W     = 5;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned OFFSETS_W  = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [FRAC_W-1:0]  DUTY_RST    = 16'd32768;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 24'd131072;
  localparam logic [ROWS_W-1:0]  HORIZON_RST = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_INC  = 3'd0,
    CFG_TABLE_INC = 3'd1,
    CFG_DUTY      = 3'd2,
    CFG_STANCE_SC = 3'd3,
    CFG_SWING_SC  = 3'd4,
    CFG_OFFSETS   = 3'd5,
    CFG_HORIZON   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CS_STANCE = 2'd0,
    CS_SWING  = 2'd1,
    CS_EARLY  = 2'd2,
    CS_LATE   = 2'd3
  } contact_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_ADV,
    ST_TICK_MUL,
    ST_TICK_WB,
    ST_TICK_EMIT,
    ST_TABLE
  } state_e;

  typedef struct packed {
    logic [FRAC_W-1:0]    tick_inc;
    logic [FRAC_W-1:0]    table_inc;
    logic [FRAC_W-1:0]    duty;
    logic [SCALE_W-1:0]   stance_scale;
    logic [SCALE_W-1:0]   swing_scale;
    logic [OFFSETS_W-1:0] leg_offsets;
    logic [ROWS_W-1:0]    horizon;
  } cfg_t;

  typedef struct packed {
    logic                 capture;
    logic                 tick_adv;
    logic                 mul;
    logic                 wb;
    logic                 tick_emit;
    logic                 row_emit;
    logic [LEG_IDX_W-1:0] leg;
    logic [ROW_W-1:0]     row;
    logic                 last_row;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- hdl/gps_ctrl.sv -----
// ----------------------------------------------------------------------------
// gps_ctrl
// Sequencer: walks a tick through the legs on the shared multiplier and
// steps a table request into the output register, one row per cycle while free.
// ----------------------------------------------------------------------------
module gps_ctrl #(
  parameter int unsigned LEGS        = 4,
  parameter int unsigned MAX_HORIZON = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_mode_i,
  output logic                          in_ready_o,
  input  logic [gps_pkg::ROWS_W-1:0]    horizon_i,
  input  gps_pkg::status_t              status_i,
  output gps_pkg::cmd_t                 cmd_o
);

  localparam int unsigned ROW_LIM_I =
    (MAX_HORIZON < gps_pkg::ROW_CAP) ? MAX_HORIZON : gps_pkg::ROW_CAP;
  localparam logic [gps_pkg::ROWS_W-1:0]    ROW_LIM  = gps_pkg::ROWS_W'(ROW_LIM_I);
  localparam logic [gps_pkg::LEG_IDX_W-1:0] LAST_LEG = gps_pkg::LEG_IDX_W'(LEGS - 1);

  gps_pkg::state_e                 state_q, state_d;
  logic [gps_pkg::LEG_IDX_W-1:0]   leg_q, leg_d;
  logic [gps_pkg::ROW_W-1:0]       row_q, row_d;
  logic [gps_pkg::ROWS_W-1:0]      rows;
  logic                            last_row;
  logic                            accept;

  assign rows     = (horizon_i > ROW_LIM) ? ROW_LIM : horizon_i;
  assign last_row = (({1'b0, row_q} + gps_pkg::ROWS_W'(1)) == rows);
  assign accept   = in_valid_i && (state_q == gps_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_mode_i ? gps_pkg::ST_TABLE : gps_pkg::ST_TICK_ADV;
        end
      end
      gps_pkg::ST_TICK_ADV: state_d = gps_pkg::ST_TICK_MUL;
      gps_pkg::ST_TICK_MUL: state_d = gps_pkg::ST_TICK_WB;
      gps_pkg::ST_TICK_WB: begin
        state_d = (leg_q == LAST_LEG) ? gps_pkg::ST_TICK_EMIT : gps_pkg::ST_TICK_MUL;
      end
      gps_pkg::ST_TICK_EMIT: begin
        if (status_i.out_free) state_d = gps_pkg::ST_IDLE;
      end
      gps_pkg::ST_TABLE: begin
        if (rows == '0) begin
          state_d = gps_pkg::ST_IDLE;
        end else if (status_i.out_free && last_row) begin
          state_d = gps_pkg::ST_IDLE;
        end
      end
      default: state_d = gps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == gps_pkg::ST_IDLE);
    cmd_o            = '0;
    cmd_o.capture    = accept;
    cmd_o.tick_adv   = (state_q == gps_pkg::ST_TICK_ADV);
    cmd_o.mul        = (state_q == gps_pkg::ST_TICK_MUL);
    cmd_o.wb         = (state_q == gps_pkg::ST_TICK_WB);
    cmd_o.tick_emit  = (state_q == gps_pkg::ST_TICK_EMIT) && status_i.out_free;
    cmd_o.row_emit   = (state_q == gps_pkg::ST_TABLE) && (rows != '0) && status_i.out_free;
    cmd_o.leg        = leg_q;
    cmd_o.row        = row_q;
    cmd_o.last_row   = last_row;
  end

  always_comb begin
    leg_d = leg_q;
    row_d = row_q;
    if (state_q == gps_pkg::ST_IDLE) begin
      leg_d = '0;
      row_d = '0;
    end
    if (cmd_o.wb && (leg_q != LAST_LEG)) leg_d = leg_q + gps_pkg::LEG_IDX_W'(1);
    if (cmd_o.row_emit) row_d = row_q + gps_pkg::ROW_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gps_pkg::ST_IDLE;
      leg_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
      row_q   <= row_d;
    end
  end

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.row_emit |-> ({1'b0, row_q} < rows))
    else $error("table row beyond horizon");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.row_emit || cmd_o.tick_emit) |-> status_i.out_free)
    else $error("emit into occupied output register");

  a_leg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gps_pkg::ST_TICK_MUL) |-> (leg_q <= LAST_LEG))
    else $error("leg index beyond leg count");

  a_tick_starts_leg0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_adv |=> ((state_q == gps_pkg::ST_TICK_MUL) && (leg_q == '0)))
    else $error("tick did not start at leg 0");

endmodule

// ----- hdl/gps_dpath.sv -----
// ----------------------------------------------------------------------------
// gps_dpath
// Phase state, per-leg phase lanes, shared scale multiplier, held leg state
// and the output register.
// ----------------------------------------------------------------------------
module gps_dpath #(
  parameter int unsigned LEGS       = 4,
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  gps_pkg::cmd_t                                   cmd_i,
  output gps_pkg::status_t                                status_o,
  input  gps_pkg::cfg_t                                   cfg_i,
  input  logic                                            in_mode_i,
  input  logic                                            in_standing_i,
  input  logic [gps_pkg::FRAC_W-1:0]                      in_start_i,
  input  logic [2*gps_pkg::MAX_LEGS-1:0]                  in_contacts_i,
  input  logic [gps_pkg::MAX_LEGS-1:0]                    in_active_i,
  input  logic                                            out_ready_i,
  output logic                                            out_valid_o,
  output logic [gps_pkg::MAX_LEGS-1:0]                    out_swing_o,
  output logic [gps_pkg::MAX_LEGS-1:0][gps_pkg::FRAC_W-1:0] out_phase_o,
  output logic [gps_pkg::ROW_W-1:0]                       out_row_o,
  output logic                                            out_last_o
);

  localparam int unsigned PW     = PHASE_BITS;
  localparam int unsigned CW     = PW + gps_pkg::FRAC_W;
  localparam int unsigned PROD_W = PW + gps_pkg::SCALE_W;
  localparam int unsigned NL     = gps_pkg::MAX_LEGS;
  localparam logic [NL-1:0] LEG_EN = NL'((5'd1 << LEGS) - 5'd1);

  logic [PW-1:0]            running_q;
  logic                     prev_standing_q;
  logic [NL-1:0]            held_swing_q;
  logic [NL-1:0][15:0]      held_phase_q;
  logic [NL-1:0]            table_swing_q;

  logic                     standing_q;
  logic [2*NL-1:0]          contacts_q;
  logic [NL-1:0]            active_q;
  logic [PW-1:0]            ph_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     stance_q;

  logic                     out_valid_q;
  logic [NL-1:0]            out_swing_q;
  logic [NL-1:0][15:0]      out_phase_q;
  logic [gps_pkg::ROW_W-1:0] out_row_q;
  logic                     out_last_q;

  logic [CW-1:0]            tick_inc_x, table_inc_x, start_x, duty_x;
  logic [PW-1:0]            tick_inc_pw, table_inc_pw, start_pw, ph_next;
  logic [NL-1:0][PW-1:0]    off_pw, tick_p, tbl_p;
  logic [NL-1:0][CW-1:0]    off_x;
  logic [NL-1:0]            tbl_lt, ts_next, row_bits;
  logic [PW-1:0]            p_sel, op;
  logic                     lt_sel;
  logic [PW+7:0]            prod_hi;
  logic [PW-1:0]            sat;
  logic [CW-1:0]            sat_x;
  logic [15:0]              sat16;
  logic                     out_free;
  gps_pkg::contact_e        cs;

  assign tick_inc_x   = {{PW{1'b0}}, cfg_i.tick_inc};
  assign table_inc_x  = {{PW{1'b0}}, cfg_i.table_inc};
  assign start_x      = {{PW{1'b0}}, in_start_i};
  assign duty_x       = {{PW{1'b0}}, cfg_i.duty};
  assign tick_inc_pw  = tick_inc_x[PW-1:0];
  assign table_inc_pw = table_inc_x[PW-1:0];
  assign start_pw     = start_x[PW-1:0];
  assign ph_next      = ph_q + table_inc_pw;

  for (genvar l = 0; l < NL; l++) begin : g_lane
    assign off_x[l]  = {{PW{1'b0}}, cfg_i.leg_offsets[16*l +: 16]};
    assign off_pw[l] = off_x[l][PW-1:0];
    assign tick_p[l] = running_q + off_pw[l];
    assign tbl_p[l]  = ph_next + off_pw[l];
    assign tbl_lt[l] = ({{gps_pkg::FRAC_W{1'b0}}, tbl_p[l]} < duty_x);
  end

  // table row: lanes are independent
  always_comb begin
    ts_next  = table_swing_q;
    row_bits = '0;
    for (int l = 0; l < NL; l++) begin
      cs = gps_pkg::contact_e'(contacts_q[2*l +: 2]);
      if (!active_q[l]) begin
        row_bits[l] = 1'b1;
      end else begin
        if (standing_q) begin
          if (tbl_lt[l] && (cs != gps_pkg::CS_SWING)) ts_next[l] = 1'b0;
        end else begin
          ts_next[l] = !tbl_lt[l];
        end
        if (cs == gps_pkg::CS_EARLY) ts_next[l] = 1'b0;
        if ((cmd_i.row == '0) && (cs == gps_pkg::CS_LATE)) ts_next[l] = 1'b1;
        row_bits[l] = ts_next[l];
      end
    end
    ts_next  = (ts_next & LEG_EN) | (table_swing_q & ~LEG_EN);
    row_bits = row_bits & LEG_EN;
  end

  // tick lane select for the shared multiplier
  assign p_sel  = tick_p[cmd_i.leg];
  assign lt_sel = ({{gps_pkg::FRAC_W{1'b0}}, p_sel} < duty_x);
  assign op     = lt_sel ? p_sel : (p_sel - duty_x[PW-1:0]);

  assign prod_hi = prod_q[PROD_W-1:16];
  assign sat     = (|prod_hi[PW+7:PW]) ? {PW{1'b1}} : prod_hi[PW-1:0];
  assign sat_x   = {{gps_pkg::FRAC_W{1'b0}}, sat};
  assign sat16   = sat_x[15:0];

  assign out_free          = !out_valid_q || out_ready_i;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      standing_q <= in_standing_i;
      contacts_q <= in_contacts_i;
      active_q   <= in_active_i;
      ph_q       <= start_pw;
    end else if (cmd_i.row_emit) begin
      ph_q <= ph_next;
    end
    if (cmd_i.mul) begin
      prod_q   <= {{gps_pkg::SCALE_W{1'b0}}, op} *
                  {{PW{1'b0}}, (lt_sel ? cfg_i.stance_scale : cfg_i.swing_scale)};
      stance_q <= lt_sel;
    end
    if (cmd_i.tick_emit) begin
      out_swing_q <= held_swing_q & LEG_EN;
      for (int l = 0; l < NL; l++) begin
        out_phase_q[l] <= LEG_EN[l] ? held_phase_q[l] : 16'd0;
      end
      out_row_q  <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.row_emit) begin
      out_swing_q <= row_bits;
      out_phase_q <= '0;
      out_row_q   <= cmd_i.row;
      out_last_q  <= cmd_i.last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q       <= '0;
      prev_standing_q <= 1'b0;
      held_swing_q    <= '0;
      held_phase_q    <= '0;
      table_swing_q   <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.capture && in_mode_i) prev_standing_q <= in_standing_i;
      if (cmd_i.tick_adv) begin
        running_q       <= ((prev_standing_q && !standing_q) ? '0 : running_q) + tick_inc_pw;
        prev_standing_q <= standing_q;
      end
      if (cmd_i.wb) begin
        if (stance_q) begin
          held_swing_q[cmd_i.leg] <= 1'b0;
          if (!standing_q) held_phase_q[cmd_i.leg] <= sat16;
        end else begin
          if (!standing_q) held_swing_q[cmd_i.leg] <= 1'b1;
          held_phase_q[cmd_i.leg] <= sat16;
        end
      end
      if (cmd_i.row_emit) table_swing_q <= ts_next;
      if (cmd_i.tick_emit || cmd_i.row_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_swing_o = out_swing_q;
  assign out_phase_o = out_phase_q;
  assign out_row_o   = out_row_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- hdl/gait_phase_scheduler.sv -----
// ----------------------------------------------------------------------------
// gait_phase_scheduler
// Tick: advance the running phase, then each leg in turn takes a multiply and a
//   write-back state on the shared scale multiplier, then the result is emitted.
// Table: one row per cycle while the output register is free; a zero horizon
//   gives no rows. A new item is accepted only while the sequencer is idle.
// Output register lets the next item be accepted while a result waits.
// Reset: asynchronous, active low; clears phase state, config to defaults.
// ----------------------------------------------------------------------------
module gait_phase_scheduler #(
  parameter int unsigned LEGS        = 4,
  parameter int unsigned MAX_HORIZON = 16,
  parameter int unsigned PHASE_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // standing, start_phase, contact_states, active_mask, zero pad
  input  logic [gps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // swing_bits, phase_leg0, phase_leg1, phase_leg2, phase_leg3, row_index
  output logic [gps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // last_row
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  gps_pkg::cfg_t    cfg_q;
  gps_pkg::cmd_t    cmd;
  gps_pkg::status_t status;

  logic [gps_pkg::MAX_LEGS-1:0]                       out_swing;
  logic [gps_pkg::MAX_LEGS-1:0][gps_pkg::FRAC_W-1:0]  out_phase;
  logic [gps_pkg::ROW_W-1:0]                          out_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_inc     <= '0;
      cfg_q.table_inc    <= '0;
      cfg_q.duty         <= gps_pkg::DUTY_RST;
      cfg_q.stance_scale <= gps_pkg::SCALE_RST;
      cfg_q.swing_scale  <= gps_pkg::SCALE_RST;
      cfg_q.leg_offsets  <= '0;
      cfg_q.horizon      <= gps_pkg::HORIZON_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gps_pkg::CFG_TICK_INC:  cfg_q.tick_inc     <= cfg_data_i[gps_pkg::FRAC_W-1:0];
        gps_pkg::CFG_TABLE_INC: cfg_q.table_inc    <= cfg_data_i[gps_pkg::FRAC_W-1:0];
        gps_pkg::CFG_DUTY:      cfg_q.duty         <= cfg_data_i[gps_pkg::FRAC_W-1:0];
        gps_pkg::CFG_STANCE_SC: cfg_q.stance_scale <= cfg_data_i[gps_pkg::SCALE_W-1:0];
        gps_pkg::CFG_SWING_SC:  cfg_q.swing_scale  <= cfg_data_i[gps_pkg::SCALE_W-1:0];
        gps_pkg::CFG_OFFSETS:   cfg_q.leg_offsets  <= cfg_data_i[gps_pkg::OFFSETS_W-1:0];
        gps_pkg::CFG_HORIZON:   cfg_q.horizon      <= cfg_data_i[gps_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  gps_ctrl #(
    .LEGS        (LEGS),
    .MAX_HORIZON (MAX_HORIZON)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .horizon_i  (cfg_q.horizon),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gps_dpath #(
    .LEGS       (LEGS),
    .PHASE_BITS (PHASE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_i         (cfg_q),
    .in_mode_i     (s_axis_tuser),
    .in_standing_i (s_axis_tdata[0]),
    .in_start_i    (s_axis_tdata[16:1]),
    .in_contacts_i (s_axis_tdata[24:17]),
    .in_active_i   (s_axis_tdata[28:25]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_swing_o   (out_swing),
    .out_phase_o   (out_phase),
    .out_row_o     (out_row),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_row, out_phase[3], out_phase[2], out_phase[1], out_phase[0],
                         out_swing};

endmodule

// ----- tb/gait_checker.sv -----
// ----------------------------------------------------------------------------
// gait_checker
// Watches the command and row streams and the register port of the gait
// phase scheduler. It keeps its own copy of the gait clock state, predicts
// the rows of every accepted command and compares each row transfer, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
package gait_tb_pkg;

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_TABLE = 1'b1
  } gait_mode_e;

  // {tuser, tdata} of the command stream
  typedef struct packed {
    gait_mode_e  mode;
    logic [2:0]  pad;
    logic [3:0]  active;
    logic [7:0]  contacts;
    logic [15:0] start_phase;
    logic        standing;
  } gait_cmd_t;

  // {tlast, tdata} of the row stream
  typedef struct packed {
    logic             last_row;
    logic [3:0]       row_index;
    logic [3:0][15:0] norm_phase;
    logic [3:0]       swing_bits;
  } gait_row_t;

  localparam int unsigned SETTLE_CYCLES = 20;

endpackage

module gait_checker
  import gps_pkg::*;
  import gait_tb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  logic                   cmd_ready_i,
  input  logic [IN_TDATA_W-1:0]  cmd_data_i,
  input  logic                   cmd_user_i,
  input  logic                   row_valid_i,
  input  logic                   row_ready_i,
  input  logic [OUT_TDATA_W-1:0] row_data_i,
  input  logic                   row_last_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned            mismatches_o,
  output int unsigned            rows_pending_o
);

  cfg_t                            regs;
  logic [FRAC_W-1:0]               run_phase;
  logic                            was_standing;
  logic [MAX_LEGS-1:0]             hold_swing;
  logic [MAX_LEGS-1:0][FRAC_W-1:0] hold_phase;
  logic [MAX_LEGS-1:0]             plan_swing;
  gait_row_t                       rows_due[$];

  function automatic logic [FRAC_W-1:0] scale_frac(input logic [FRAC_W-1:0] frac,
                                                   input logic [SCALE_W-1:0] k);
    logic [39:0] prod;
    prod = {24'd0, frac} * {16'd0, k};
    if (|prod[39:32]) begin
      return '1;
    end
    return prod[31:16];
  endfunction

  function automatic logic [FRAC_W-1:0] leg_frac(input logic [FRAC_W-1:0] base,
                                                 input int unsigned leg);
    logic [FRAC_W-1:0] p;
    p = base + regs.leg_offsets[FRAC_W*leg +: FRAC_W];
    return p;
  endfunction

  task automatic advance_tick(input logic standing);
    gait_row_t         row;
    logic [FRAC_W-1:0] p;
    row = '0;
    if (was_standing && !standing) begin
      run_phase = '0;
    end
    run_phase = run_phase + regs.tick_inc;
    for (int unsigned leg = 0; leg < MAX_LEGS; leg++) begin
      p = leg_frac(run_phase, leg);
      if (p < regs.duty) begin
        hold_swing[leg] = 1'b0;
        if (!standing) begin
          hold_phase[leg] = scale_frac(p, regs.stance_scale);
        end
      end else begin
        if (!standing) begin
          hold_swing[leg] = 1'b1;
        end
        hold_phase[leg] = scale_frac(p - regs.duty, regs.swing_scale);
      end
      row.swing_bits[leg] = hold_swing[leg];
      row.norm_phase[leg] = hold_phase[leg];
    end
    row.last_row = 1'b1;
    rows_due.push_back(row);
    was_standing = standing;
  endtask

  task automatic plan_table(input gait_cmd_t cmd);
    gait_row_t         row;
    logic [FRAC_W-1:0] ph;
    logic [FRAC_W-1:0] p;
    contact_e          cs;
    int unsigned       rows;
    rows = (regs.horizon > ROW_CAP) ? ROW_CAP : regs.horizon;
    ph   = cmd.start_phase;
    for (int unsigned r = 0; r < rows; r++) begin
      row = '0;
      ph  = ph + regs.table_inc;
      for (int unsigned leg = 0; leg < MAX_LEGS; leg++) begin
        cs = contact_e'(cmd.contacts[2*leg +: 2]);
        if (!cmd.active[leg]) begin
          row.swing_bits[leg] = 1'b1;
        end else begin
          p = leg_frac(ph, leg);
          if (cmd.standing) begin
            if (p < regs.duty && cs != CS_SWING) begin
              plan_swing[leg] = 1'b0;
            end
          end else begin
            plan_swing[leg] = (p >= regs.duty);
          end
          if (cs == CS_EARLY) begin
            plan_swing[leg] = 1'b0;
          end
          if (r == 0 && cs == CS_LATE) begin
            plan_swing[leg] = 1'b1;
          end
          row.swing_bits[leg] = plan_swing[leg];
        end
      end
      row.row_index = r[ROW_W-1:0];
      row.last_row  = (r + 1 == rows);
      rows_due.push_back(row);
    end
    was_standing = cmd.standing;
  endtask

  task automatic flag_field(input string name, input logic [15:0] want,
                            input logic [15:0] seen);
    $display("%0t: %s expected %h got %h", $time, name, want, seen);
    mismatches_o++;
  endtask

  task automatic check_row(input gait_row_t seen);
    gait_row_t want;
    if (rows_due.size() == 0) begin
      $display("%0t: row transfer with none expected, got %h", $time, seen);
      mismatches_o++;
    end else begin
      want = rows_due.pop_front();
      if (seen.swing_bits !== want.swing_bits) begin
        flag_field("swing_bits", 16'(want.swing_bits), 16'(seen.swing_bits));
      end
      for (int unsigned leg = 0; leg < MAX_LEGS; leg++) begin
        if (seen.norm_phase[leg] !== want.norm_phase[leg]) begin
          flag_field($sformatf("phase_leg%0d", leg), want.norm_phase[leg],
                     seen.norm_phase[leg]);
        end
      end
      if (seen.row_index !== want.row_index) begin
        flag_field("row_index", 16'(want.row_index), 16'(seen.row_index));
      end
      if (seen.last_row !== want.last_row) begin
        flag_field("last_row", 16'(want.last_row), 16'(seen.last_row));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.tick_inc     = '0;
      regs.table_inc    = '0;
      regs.duty         = DUTY_RST;
      regs.stance_scale = SCALE_RST;
      regs.swing_scale  = SCALE_RST;
      regs.leg_offsets  = '0;
      regs.horizon      = HORIZON_RST;
      run_phase         = '0;
      was_standing      = 1'b0;
      hold_swing        = '0;
      hold_phase        = '0;
      plan_swing        = '0;
      rows_due.delete();
      mismatches_o      = 0;
      rows_pending_o    = 0;
    end else begin
      if (row_valid_i && row_ready_i) begin
        check_row({row_last_i, row_data_i});
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TICK_INC:  regs.tick_inc     = cfg_data_i[FRAC_W-1:0];
          CFG_TABLE_INC: regs.table_inc    = cfg_data_i[FRAC_W-1:0];
          CFG_DUTY:      regs.duty         = cfg_data_i[FRAC_W-1:0];
          CFG_STANCE_SC: regs.stance_scale = cfg_data_i[SCALE_W-1:0];
          CFG_SWING_SC:  regs.swing_scale  = cfg_data_i[SCALE_W-1:0];
          CFG_OFFSETS:   regs.leg_offsets  = cfg_data_i[OFFSETS_W-1:0];
          CFG_HORIZON:   regs.horizon      = cfg_data_i[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i) begin
        if (gait_mode_e'(cmd_user_i) == MODE_TICK) begin
          advance_tick(cmd_data_i[0]);
        end else begin
          plan_table(gait_cmd_t'({cmd_user_i, cmd_data_i}));
        end
      end
      rows_pending_o = rows_due.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the gait phase scheduler with directed and random tick and table
// commands under several register settings, with random idling on both
// streams, and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  import gps_pkg::*;
  import gait_tb_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 50;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx       = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  int unsigned            mismatches;
  int unsigned            rows_pending;
  int unsigned            idle_odds     = 4;
  int unsigned            quiet         = 0;

  gait_phase_scheduler i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  gait_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cmd_valid_i    (s_axis_tvalid),
    .cmd_ready_i    (s_axis_tready),
    .cmd_data_i     (s_axis_tdata),
    .cmd_user_i     (s_axis_tuser),
    .row_valid_i    (m_axis_tvalid),
    .row_ready_i    (m_axis_tready),
    .row_data_i     (m_axis_tdata),
    .row_last_i     (m_axis_tlast),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .rows_pending_o (rows_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // row sink: stall bursts while idling is on
  always begin
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  task automatic send(input gait_mode_e mode, input logic standing,
                      input logic [15:0] start, input logic [7:0] contacts,
                      input logic [3:0] active);
    gait_cmd_t cmd;
    cmd = '{mode: mode, pad: 3'b000, active: active, contacts: contacts,
            start_phase: start, standing: standing};
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid                <= 1'b1;
    {s_axis_tuser, s_axis_tdata} <= cmd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // wait until every predicted row has come out and the block is idle
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] tick_inc, input logic [15:0] row_inc,
                              input logic [15:0] duty, input logic [23:0] stance_k,
                              input logic [23:0] swing_k, input logic [63:0] offsets,
                              input logic [4:0] rows);
    settle();
    write_reg(CFG_TICK_INC, 64'(tick_inc));
    write_reg(CFG_TABLE_INC, 64'(row_inc));
    write_reg(CFG_DUTY, 64'(duty));
    write_reg(CFG_STANCE_SC, 64'(stance_k));
    write_reg(CFG_SWING_SC, 64'(swing_k));
    write_reg(CFG_OFFSETS, offsets);
    write_reg(CFG_HORIZON, 64'(rows));
  endtask

  function automatic logic [23:0] recip(input logic [16:0] frac);
    logic [63:0] q;
    if (frac == 0) begin
      return '1;
    end
    q = (64'd1 << 32) / frac;
    return (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
  endfunction

  initial begin
    logic        stand;
    logic [15:0] duty;
    logic [4:0]  rows;
    logic [63:0] offsets;
    logic [3:0]  active;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'hF);
    send(MODE_TABLE, 1'b0, 16'h4000, 8'h00, 4'hF);

    // trot-like setup, full horizon
    program_regs(16'h2345, 16'h1800, 16'h9000, recip(17'h9000), recip(17'h7000),
                 64'hC000_8000_4000_0000, 5'd16);
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'h0);
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'h0);
    send(MODE_TICK, 1'b1, 16'h0000, 8'h00, 4'h0);
    send(MODE_TICK, 1'b1, 16'h0000, 8'h00, 4'h0);
    // standing falls: phase restarts
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'h0);
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'h0);
    send(MODE_TABLE, 1'b1, 16'h0000, 8'h00, 4'hF);
    send(MODE_TABLE, 1'b1, 16'h8000, 8'h55, 4'hF);
    send(MODE_TABLE, 1'b0, 16'h1234, 8'hAA, 4'hF);
    send(MODE_TABLE, 1'b0, 16'h9ABC, 8'hFF, 4'hF);
    send(MODE_TABLE, 1'b1, 16'h7777, 8'hE4, 4'h5);
    send(MODE_TABLE, 1'b0, 16'hFFFF, 8'h1B, 4'h0);
    send(MODE_TABLE, 1'b0, 16'h0000, 8'hE4, 4'hA);

    // all-ones extremes, horizon saturates
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, '1, 5'd31);
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'hF);
    send(MODE_TICK, 1'b1, 16'h0000, 8'h00, 4'hF);
    send(MODE_TABLE, 1'b0, 16'hFFFF, 8'h00, 4'hF);

    // zero duty, zero scales, empty horizon
    program_regs(16'h0001, 16'h0001, 16'h0000, 24'h00_0000, 24'h00_0000, '0, 5'd0);
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'hF);
    send(MODE_TABLE, 1'b0, 16'h0000, 8'hFF, 4'hF);
    send(MODE_TICK, 1'b1, 16'h0000, 8'h00, 4'hF);

    // single row, minimal duty
    program_regs(16'h0100, 16'hF000, 16'h0001, 24'h80_0000, 24'h01_0001,
                 {$urandom, $urandom}, 5'd1);
    send(MODE_TABLE, 1'b0, 16'hFFFE, 8'hC3, 4'hF);
    send(MODE_TICK, 1'b0, 16'h0000, 8'h00, 4'hF);

    stand = 1'b0;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       duty = 16'h0001;
        1:       duty = 16'hFFFF;
        2:       duty = 16'h0000;
        default: duty = 16'($urandom_range(16'h1000, 16'hF000));
      endcase
      rows    = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 16));
      offsets = ($urandom_range(0, 1) == 0) ? 64'h8000_0000_0000_8000
                                            : {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0) begin
        program_regs(16'($urandom), 16'($urandom), duty, 24'($urandom), 24'($urandom),
                     offsets, rows);
      end else begin
        program_regs(16'($urandom_range(1, 16'h0800)),
                     16'($urandom_range(16'h0400, 16'h2000)),
                     duty, recip({1'b0, duty}), recip(17'h1_0000 - duty), offsets, rows);
      end
      idle_odds = (phase == PHASES - 1 || phase == 3) ? 0 : $urandom_range(2, 6);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          stand = !stand;
        end
        active = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom);
        send(($urandom_range(0, 2) == 0) ? MODE_TABLE : MODE_TICK, stand,
             16'($urandom), 8'($urandom), active);
      end
    end

    settle();
    if (mismatches == 0 && rows_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
